// ----- src/ght_pkg.sv -----
`default_nettype none

package ght_pkg;

  // active bits are searched in words: first a word that is not full, then a free bit in it
  localparam int WORD_W  = 16;
  localparam int WORD_AW = 4;

  localparam logic [15:0] NO_INDEX = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_PUT      = 2'd0,
    REQ_RELEASE  = 2'd1,
    REQ_LOOKUP   = 2'd2,
    REQ_RESERVED = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_INACTIVE  = 3'd3,
    ST_STALE     = 3'd4,
    ST_TYPE      = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] gen;
    logic [5:0]  tag;
    logic [31:0] obj;
  } slot_word_t;

  typedef struct packed {
    logic accept;
    logic find_word;
    logic find_bit;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_put;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/ght_req_if.sv -----
`default_nettype none

interface ght_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] object_ref;
  logic [5:0]  entry_type;
  logic [15:0] handle_index;
  logic [8:0]  handle_generation;

  modport source (
    output valid, req_type, object_ref, entry_type, handle_index, handle_generation,
    input  ready
  );

  modport sink (
    input  valid, req_type, object_ref, entry_type, handle_index, handle_generation,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/ght_rsp_if.sv -----
`default_nettype none

interface ght_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_index;
  logic [8:0]  out_generation;
  logic [5:0]  out_type;
  logic [31:0] out_object_ref;

  modport source (
    output valid, status, out_index, out_generation, out_type, out_object_ref,
    input  ready
  );

  modport sink (
    input  valid, status, out_index, out_generation, out_type, out_object_ref,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/generational_handle_table.sv -----
// generational handle table
// requests arrive on the req channel (valid/ready); a transfer takes place at a
// rising edge with valid and ready both high. each request gives exactly one
// response transfer on the rsp channel, in request order.
// request kinds: put claims the lowest free slot, release frees a slot whose
// handle generation matches, lookup also checks the type and returns the object.
// sequence: release and lookup go from the request transfer straight to the
// execute step, which loads the response register; put first runs the free
// slot search, first over the per-word full flags, then over the bits of the
// chosen word; the rest is one read-modify-write of the slot memory.
// the response sits in an output register, so a new request is taken while an
// earlier response still waits; if the receiver stalls with a response held,
// the next request runs up to its execute step and waits there.
// reset (rst, synchronous) clears all active bits, marks every generation as
// zero through per-slot valid bits and empties the response register; no
// clearing pass is needed and requests are taken in the first cycle after reset.
`default_nettype none

module generational_handle_table
  import ght_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic      clk,
  input  logic      rst,
  ght_req_if.sink   req,
  ght_rsp_if.source rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: idle, free slot search, execute
  ght_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot state, search logic, checks and response register
  ght_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_req_type          (req.req_type),
    .in_object_ref        (req.object_ref),
    .in_entry_type        (req.entry_type),
    .in_handle_index      (req.handle_index),
    .in_handle_generation (req.handle_generation),
    .out_valid            (rsp.valid),
    .out_ready            (rsp.ready),
    .out_status           (rsp.status),
    .out_index            (rsp.out_index),
    .out_generation       (rsp.out_generation),
    .out_type             (rsp.out_type),
    .out_object_ref       (rsp.out_object_ref)
  );

endmodule

`default_nettype wire

// ----- src/ght_ctrl.sv -----
`default_nettype none

module ght_ctrl
  import ght_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND_WORD,
    S_FIND_BIT,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept    = in_ready && in_valid;
    cmd.find_word = (state == S_FIND_WORD);
    cmd.find_bit  = (state == S_FIND_BIT);
    cmd.exec      = (state == S_EXEC) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= stat.in_is_put ? S_FIND_WORD : S_EXEC;
          end
        end
        S_FIND_WORD: state <= S_FIND_BIT;
        S_FIND_BIT:  state <= S_EXEC;
        S_EXEC: begin
          if (stat.out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_exec_reopens: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> in_ready)
    else $error("input not reopened after execute");

  a_put_searches: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && stat.in_is_put |=> state == S_FIND_WORD)
    else $error("put did not start free slot search");

  a_handle_direct: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !stat.in_is_put |=> state == S_EXEC && !in_ready)
    else $error("handle request did not go to execute");
`endif

endmodule

`default_nettype wire

// ----- src/ght_dp.sv -----
`default_nettype none

module ght_dp
  import ght_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_object_ref,
  input  logic [5:0]  in_entry_type,
  input  logic [15:0] in_handle_index,
  input  logic [8:0]  in_handle_generation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_index,
  output logic [8:0]  out_generation,
  output logic [5:0]  out_type,
  output logic [31:0] out_object_ref
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW  = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
  localparam int PW  = NW * WORD_W;
  localparam int SW  = WIW + WORD_AW;
  localparam logic [16:0] SLOTS_LIM = 17'(SLOTS);

  // padding bits above SLOTS stay set so the search never picks them
  logic [PW-1:0]    active;
  logic [SLOTS-1:0] gen_valid;
  slot_word_t       mem [SLOTS];

  slot_word_t       rd_word;
  logic             rd_gval;
  req_kind_t        req_kind;
  logic [31:0]      req_obj;
  logic [5:0]       req_tag;
  logic [8:0]       req_gen;
  logic             bad_index;
  logic [IW-1:0]    slot_idx;
  logic [WIW-1:0]   word_idx;
  logic             full;
  status_t          out_st;

  // free slot search, word level then bit level
  logic [NW-1:0]     word_full;
  logic [WIW-1:0]    first_word;
  logic              any_free;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_AW-1:0] first_bit;
  logic [SW-1:0]     found_wide;
  logic [IW-1:0]     found_idx;
  logic [IW-1:0]     rd_addr;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      word_full[w] = &active[w*WORD_W +: WORD_W];
    end
    any_free   = 1'b0;
    first_word = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (!word_full[w]) begin
        any_free   = 1'b1;
        first_word = WIW'(w);
      end
    end
  end

  always_comb begin
    cur_word  = active[{word_idx, {WORD_AW{1'b0}}} +: WORD_W];
    first_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!cur_word[b]) begin
        first_bit = WORD_AW'(b);
      end
    end
    found_wide = {word_idx, first_bit};
    found_idx  = found_wide[IW-1:0];
    rd_addr    = cmd.find_bit ? found_idx : in_handle_index[IW-1:0];
  end

  assign stat.in_is_put = (in_req_type == REQ_PUT);
  assign stat.out_free  = !out_valid || out_ready;

  // execute decision
  logic [15:0] gen_eff;
  logic        wr_en;
  slot_word_t  wr_word;
  logic        set_act;
  logic        clr_act;
  status_t     nx_st;
  logic [15:0] nx_index;
  logic [8:0]  nx_gen;
  logic [5:0]  nx_type;
  logic [31:0] nx_obj;

  always_comb begin
    gen_eff  = rd_gval ? rd_word.gen : 16'd0;
    wr_en    = 1'b0;
    wr_word  = rd_word;
    set_act  = 1'b0;
    clr_act  = 1'b0;
    nx_st    = ST_BAD_INDEX;
    nx_index = NO_INDEX;
    nx_gen   = '0;
    nx_type  = '0;
    nx_obj   = '0;
    case (req_kind)
      REQ_PUT: begin
        if (full) begin
          nx_st = ST_FULL;
        end else begin
          nx_st       = ST_OK;
          nx_index    = 16'(slot_idx);
          nx_gen      = gen_eff[8:0];
          nx_type     = req_tag;
          wr_en       = 1'b1;
          wr_word.gen = gen_eff;
          wr_word.tag = req_tag;
          wr_word.obj = req_obj;
          set_act     = 1'b1;
        end
      end
      REQ_RELEASE, REQ_LOOKUP: begin
        if (bad_index) begin
          nx_st = ST_BAD_INDEX;
        end else if (!active[slot_idx]) begin
          nx_st = ST_INACTIVE;
        end else if (gen_eff[8:0] != req_gen) begin
          nx_st = ST_STALE;
        end else if (req_kind == REQ_RELEASE) begin
          nx_st       = ST_OK;
          nx_index    = 16'(slot_idx);
          wr_en       = 1'b1;
          wr_word.gen = gen_eff + 16'd1;
          wr_word.obj = '0;
          clr_act     = 1'b1;
        end else if (rd_word.tag != req_tag) begin
          nx_st = ST_TYPE;
        end else begin
          nx_st    = ST_OK;
          nx_index = 16'(slot_idx);
          nx_gen   = gen_eff[8:0];
          nx_type  = rd_word.tag;
          nx_obj   = rd_word.obj;
        end
      end
      default: nx_st = ST_BAD_INDEX;
    endcase
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.find_bit) begin
      rd_word <= mem[rd_addr];
    end
    if (cmd.exec && wr_en) begin
      mem[slot_idx] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_kind  <= req_kind_t'(in_req_type);
      req_obj   <= in_object_ref;
      req_tag   <= in_entry_type;
      req_gen   <= in_handle_generation;
      bad_index <= ({1'b0, in_handle_index} >= SLOTS_LIM) || (in_handle_index == NO_INDEX);
    end
    if (cmd.find_word) begin
      word_idx <= first_word;
      full     <= !any_free;
    end
    if (cmd.accept) begin
      slot_idx <= in_handle_index[IW-1:0];
    end else if (cmd.find_bit) begin
      slot_idx <= found_idx;
    end
    if (cmd.exec) begin
      out_st         <= nx_st;
      out_index      <= nx_index;
      out_generation <= nx_gen;
      out_type       <= nx_type;
      out_object_ref <= nx_obj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < PW; b++) begin
        active[b] <= (b >= SLOTS);
      end
      gen_valid <= '0;
      rd_gval   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept || cmd.find_bit) begin
        rd_gval <= gen_valid[rd_addr];
      end
      if (cmd.exec && wr_en) begin
        gen_valid[slot_idx] <= 1'b1;
      end
      if (cmd.exec && set_act) begin
        active[slot_idx] <= 1'b1;
      end else if (cmd.exec && clr_act) begin
        active[slot_idx] <= 1'b0;
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_status = out_st;

`ifndef SYNTHESIS
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("execute produced no result");

  a_put_claims: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && set_act |=> active[$past(slot_idx)] && out_status == ST_OK)
    else $error("put did not claim its slot");

  a_release_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && clr_act |=> !active[$past(slot_idx)] && gen_valid[$past(slot_idx)])
    else $error("release did not free its slot");
`endif

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

// checks generational_handle_table against a bit-level predictor of the slot table
// a driver and a monitor run as clocked always blocks; the driver pops requests
// from a queue that is planned up front, the monitor compares every response
// transfer with the oldest predicted response
module testbench;
  import ght_pkg::*;

  localparam int SLOTS      = 256;
  localparam int QUIET_TAIL = 60;    // last requests go through with no idling
  localparam int HOLD_AT    = 100;   // request count at which the sink holds off
  localparam int HOLD_LEN   = 150;   // length of that hold-off in cycles
  localparam int WATCHDOG   = 1000;  // cycles with no transfer before giving up
  localparam int MAX_SHOWN  = 10;

  // two copies of the predicted slot table: one steers the planning of the
  // stimulus, the other follows the accepted request transfers
  localparam int PLAN_SIDE  = 0;
  localparam int CHECK_SIDE = 1;

  typedef struct packed {
    req_kind_t   kind;
    logic [31:0] obj;
    logic [5:0]  tag;
    logic [15:0] idx;
    logic [8:0]  gen;
  } handle_req_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] idx;
    logic [8:0]  gen;
    logic [5:0]  tag;
    logic [31:0] obj;
  } handle_rsp_t;

  logic clk;
  logic rst;

  ght_req_if req_ch ();
  ght_rsp_if rsp_ch ();

  generational_handle_table #(.SLOTS(SLOTS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // predicted slot state
  bit          slot_live [2][SLOTS];
  logic [15:0] slot_gen  [2][SLOTS];
  logic [5:0]  slot_tag  [2][SLOTS];
  logic [31:0] slot_obj  [2][SLOTS];

  handle_req_t pending_reqs [$];
  handle_rsp_t expected_rsps [$];
  handle_req_t cur_req;
  handle_rsp_t got_rsp;
  handle_rsp_t want_rsp;

  int total_reqs;
  int reqs_sent;
  int rsps_seen;
  int fault_count;
  int src_gap;
  int sink_gap;
  int hold_left;
  bit hold_done;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // index range, then active bit, then the 9-bit generation
  function automatic status_t handle_check(int side, logic [15:0] idx, logic [8:0] gen);
    if (idx == NO_INDEX || idx >= SLOTS) return ST_BAD_INDEX;
    if (!slot_live[side][idx]) return ST_INACTIVE;
    if (slot_gen[side][idx][8:0] != gen) return ST_STALE;
    return ST_OK;
  endfunction

  // applies one request to a table copy and returns the response it gives
  function automatic handle_rsp_t serve_request(int side, handle_req_t r);
    handle_rsp_t e;
    int free_slot;
    status_t st;
    e.st = ST_BAD_INDEX;
    e.idx = NO_INDEX;
    e.gen = '0;
    e.tag = '0;
    e.obj = '0;
    free_slot = -1;
    case (r.kind)
      REQ_PUT: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!slot_live[side][i]) free_slot = i;
        if (free_slot < 0) begin
          e.st = ST_FULL;
        end else begin
          // a reused slot keeps its current generation
          slot_live[side][free_slot] = 1'b1;
          slot_tag[side][free_slot] = r.tag;
          slot_obj[side][free_slot] = r.obj;
          e.st = ST_OK;
          e.idx = 16'(free_slot);
          e.gen = slot_gen[side][free_slot][8:0];
          e.tag = r.tag;
        end
      end
      REQ_RELEASE: begin
        // release never looks at the type
        st = handle_check(side, r.idx, r.gen);
        e.st = st;
        if (st == ST_OK) begin
          slot_live[side][r.idx] = 1'b0;
          slot_obj[side][r.idx] = '0;
          slot_gen[side][r.idx] = slot_gen[side][r.idx] + 16'd1;
          e.idx = r.idx;
        end
      end
      REQ_LOOKUP: begin
        st = handle_check(side, r.idx, r.gen);
        if (st == ST_OK && slot_tag[side][r.idx] != r.tag) st = ST_TYPE;
        e.st = st;
        if (st == ST_OK) begin
          e.idx = r.idx;
          e.gen = slot_gen[side][r.idx][8:0];
          e.tag = slot_tag[side][r.idx];
          e.obj = slot_obj[side][r.idx];
        end
      end
      default: ;  // reserved kind: bad index, no change
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------

  task automatic plan_item(req_kind_t kind, logic [31:0] obj, logic [5:0] tag,
                           logic [15:0] idx, logic [8:0] gen);
    handle_req_t r;
    handle_rsp_t unused;
    r.kind = kind;
    r.obj = obj;
    r.tag = tag;
    r.idx = idx;
    r.gen = gen;
    unused = serve_request(PLAN_SIDE, r);
    pending_reqs.push_back(r);
  endtask

  // a random live slot of the planning copy, or -1 when none is live
  function automatic int pick_live();
    int live [$];
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[PLAN_SIDE][i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[PLAN_SIDE][i]) n++;
    return n;
  endfunction

  task automatic plan_random_put();
    plan_item(REQ_PUT, $urandom, 6'($urandom), 16'($urandom), 9'($urandom));
  endtask

  // fully random request, handle near the table or anywhere in 16 bits, each half the time
  task automatic plan_noise();
    logic [15:0] idx;
    if ($urandom_range(0, 1) == 0) idx = 16'($urandom);
    else idx = 16'($urandom_range(0, SLOTS + 3));
    plan_item(req_kind_t'($urandom_range(0, 3)), $urandom, 6'($urandom), idx,
              9'($urandom));
  endtask

  task automatic plan_stimulus();
    int s;
    int pick;
    // directed: edge values and each checking rule
    plan_item(REQ_LOOKUP,  32'h0, 6'h00, 16'd0, 9'h000);          // inactive
    plan_item(REQ_RELEASE, 32'h0, 6'h00, 16'd0, 9'h000);          // inactive
    plan_item(REQ_PUT, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 9'h1FF);   // slot 0
    plan_item(REQ_PUT, 32'h0000_0000, 6'h00, 16'h0000, 9'h000);   // slot 1
    plan_item(REQ_LOOKUP,  32'h0, 6'h3F, 16'd0, 9'h000);          // ok
    plan_item(REQ_LOOKUP,  32'hFFFF_FFFF, 6'h00, 16'd1, 9'h000);  // stored zero
    plan_item(REQ_LOOKUP,  32'h0, 6'h3E, 16'd0, 9'h000);          // type mismatch
    plan_item(REQ_LOOKUP,  32'h0, 6'h00, 16'd0, 9'h001);          // stale, before type
    plan_item(REQ_LOOKUP,  32'h0, 6'h3F, 16'hFFFF, 9'h1FF);       // invalid index
    plan_item(REQ_RELEASE, 32'h0, 6'h3F, 16'(SLOTS), 9'h000);     // first out of range
    plan_item(REQ_RELEASE, 32'h0, 6'h3F, 16'h8000, 9'h000);       // far out of range
    plan_item(REQ_LOOKUP,  32'h0, 6'h00, 16'(SLOTS - 1), 9'h000); // inactive
    plan_item(REQ_RELEASE, 32'h0, 6'h01, 16'd0, 9'h000);          // ok, type ignored
    plan_item(REQ_LOOKUP,  32'h0, 6'h3F, 16'd0, 9'h000);          // now inactive
    plan_item(REQ_RELEASE, 32'h0, 6'h3F, 16'd0, 9'h000);          // double release
    plan_item(REQ_PUT, 32'hA5A5_5A5A, 6'h15, 16'd0, 9'h000);      // reuse slot 0, gen 1
    plan_item(REQ_LOOKUP,  32'h0, 6'h15, 16'd0, 9'h000);          // old handle stale
    plan_item(REQ_LOOKUP,  32'h0, 6'h15, 16'd0, 9'h001);          // new handle ok
    plan_item(REQ_RESERVED, 32'h1234_5678, 6'h2A, 16'd0, 9'h001); // reserved kind
    plan_item(REQ_RESERVED, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 9'h1FF);
    plan_item(REQ_RELEASE, 32'h0, 6'h00, 16'd1, 9'h1FF);          // stale release
    plan_item(REQ_PUT, 32'h5A5A_A5A5, 6'h2A, 16'hFFFF, 9'h1FF);   // slot 2
    plan_item(REQ_LOOKUP,  32'h0, 6'h15, 16'h7FFF, 9'h0AA);

    // fill the table, then push past full
    while (live_count() < SLOTS) plan_random_put();
    repeat (3) plan_random_put();
    plan_item(REQ_LOOKUP, 32'h0, slot_tag[PLAN_SIDE][SLOTS - 1], 16'(SLOTS - 1),
              slot_gen[PLAN_SIDE][SLOTS - 1][8:0]);
    plan_item(REQ_RELEASE, 32'h0, 6'h00, 16'(SLOTS - 1),
              ~slot_gen[PLAN_SIDE][SLOTS - 1][8:0]);
    plan_item(REQ_LOOKUP, 32'h0, 6'h00, 16'(SLOTS), 9'h000);

    // punch holes, then refill lowest first until full again
    repeat (20) begin
      s = pick_live();
      plan_item(REQ_RELEASE, $urandom, 6'($urandom), 16'(s), slot_gen[PLAN_SIDE][s][8:0]);
    end
    repeat (25) plan_random_put();

    // random mix, mostly valid handles
    repeat (330) begin
      pick = $urandom_range(0, 99);
      s = pick_live();
      if (pick < 35 || s < 0) begin
        plan_random_put();
      end else if (pick < 62) begin
        plan_item(REQ_RELEASE, $urandom, 6'($urandom), 16'(s),
                  slot_gen[PLAN_SIDE][s][8:0]);
      end else if (pick < 80) begin
        plan_item(REQ_LOOKUP, $urandom, slot_tag[PLAN_SIDE][s], 16'(s),
                  slot_gen[PLAN_SIDE][s][8:0]);
      end else if (pick < 84) begin
        plan_item(REQ_LOOKUP, $urandom, slot_tag[PLAN_SIDE][s] ^ 6'($urandom_range(1, 63)),
                  16'(s), slot_gen[PLAN_SIDE][s][8:0]);
      end else if (pick < 89) begin
        plan_item(req_kind_t'($urandom_range(1, 2)), $urandom, slot_tag[PLAN_SIDE][s],
                  16'(s), slot_gen[PLAN_SIDE][s][8:0] ^ 9'($urandom_range(1, 511)));
      end else begin
        plan_noise();
      end
    end
  endtask

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_SHOWN) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      // transfer of the request on the bus: predict its response now
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(serve_request(CHECK_SIDE, cur_req));
        reqs_sent++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered request until it is taken
      end else if (src_gap > 0) begin
        src_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() >= QUIET_TAIL && hold_left == 0 &&
                   $urandom_range(0, 11) == 0) begin
        // idle burst of random length, beginning now
        src_gap = $urandom_range(1, 18) - 1;
        req_ch.valid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        req_ch.req_type          <= cur_req.kind;
        req_ch.object_ref        <= cur_req.obj;
        req_ch.entry_type        <= cur_req.tag;
        req_ch.handle_index      <= cur_req.idx;
        req_ch.handle_generation <= cur_req.gen;
        req_ch.valid             <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response monitor
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      sink_gap = 0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_rsp.st  = status_t'(rsp_ch.status);
        got_rsp.idx = rsp_ch.out_index;
        got_rsp.gen = rsp_ch.out_generation;
        got_rsp.tag = rsp_ch.out_type;
        got_rsp.obj = rsp_ch.out_object_ref;
        if (expected_rsps.size() == 0) begin
          note_fault($sformatf("response %0d with nothing predicted: st=%0d idx=%h",
                               rsps_seen, got_rsp.st, got_rsp.idx));
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (got_rsp.st !== want_rsp.st || got_rsp.idx !== want_rsp.idx ||
              got_rsp.gen !== want_rsp.gen || got_rsp.tag !== want_rsp.tag ||
              got_rsp.obj !== want_rsp.obj)
            note_fault($sformatf(
              "response %0d: expected st=%0d idx=%h gen=%h tag=%h obj=%h, got st=%0d idx=%h gen=%h tag=%h obj=%h",
              rsps_seen, want_rsp.st, want_rsp.idx, want_rsp.gen, want_rsp.tag,
              want_rsp.obj, got_rsp.st, got_rsp.idx, got_rsp.gen, got_rsp.tag,
              got_rsp.obj));
        end
        rsps_seen++;
      end
      // one long hold-off so the block backs up and stalls its request side
      if (!hold_done && reqs_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rsp_ch.ready <= 1'b0;
      end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 18) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles in a row with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PUT;
    req_ch.object_ref = '0;
    req_ch.entry_type = '0;
    req_ch.handle_index = '0;
    req_ch.handle_generation = '0;
    rsp_ch.ready = 1'b0;
    reqs_sent = 0;
    rsps_seen = 0;
    fault_count = 0;
    hold_done = 1'b0;
    hold_left = 0;
    idle_cycles = 0;
    // both table copies start from the reset state
    for (int c = 0; c < 2; c++)
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[c][i] = 1'b0;
        slot_gen[c][i] = '0;
        slot_tag[c][i] = '0;
        slot_obj[c][i] = '0;
      end
    plan_stimulus();
    total_reqs = pending_reqs.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // drain: every request taken and every response seen
    while (!(reqs_sent == total_reqs && expected_rsps.size() == 0)) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ght_pkg.sv
src/ght_req_if.sv
src/ght_rsp_if.sv
src/ght_ctrl.sv
src/ght_dp.sv
src/generational_handle_table.sv
bench/testbench.sv
